FILE: design/mbp_pkg.sv
package mbp_pkg;

    localparam int HIDDEN_DEF      = 2;
    localparam int SIG_ENTRIES_DEF = 256;
    localparam int DW              = 24;
    localparam int LRW             = 16;
    localparam int YW              = 16;
    localparam int IXW             = 7;
    localparam int WIDE            = 68;
    localparam int PW              = 41;  // q8.16 times an unsigned 16-bit value
    localparam int SAT_MAX         = 8388607;
    localparam int SAT_MIN         = -8388608;
    localparam logic [LRW-1:0] LR_RESET = 16'd6554;

    typedef logic signed [DW-1:0] t_q;
    typedef logic signed [PW-1:0] t_p;

    typedef enum logic {
        OP_TRAIN = 1'b0,
        OP_LOAD  = 1'b1
    } t_op;

    // one strobe per sequencer step
    typedef struct packed {
        logic f1;
        logic f2;
        logic f3;
        logic f4;
        logic sum;
        logic o1;
        logic o2;
        logic e1;
        logic e2;
        logic e3;
        logic b1;
        logic b2;
        logic b3;
        logic b4;
        logic b5;
        logic b6;
        logic b7;
    } t_ctl;

    // per-lane load strobes
    typedef struct packed {
        logic wa;
        logic wb;
        logic b;
        logic ow;
    } t_lane_ld;

    function automatic t_q f_sat(input logic signed [WIDE-1:0] v);
        if (v > WIDE'(SAT_MAX)) begin
            return t_q'(SAT_MAX);
        end
        if (v < WIDE'(SAT_MIN)) begin
            return t_q'(SAT_MIN);
        end
        return DW'(v);
    endfunction

    // round half up, then arithmetic shift
    function automatic logic signed [WIDE-1:0] f_rnd(input logic signed [WIDE-1:0] v,
                                                     input int unsigned n);
        logic signed [WIDE-1:0] half;
        half = '0;
        half[n-1] = 1'b1;
        return (v + half) >>> n;
    endfunction

    function automatic logic [YW:0] f_dsig(input logic [YW-1:0] y);
        logic [32:0] p;
        p = 33'(y) * (33'(17'h10000) - 33'(y));
        return p[32:16];
    endfunction

    // shift and subtract quotient, elaboration only
    function automatic longint unsigned f_udiv(input longint unsigned a,
                                               input longint unsigned b);
        logic [64:0]     rem;
        longint unsigned q;
        rem = '0;
        q   = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], a[i]};
            if (rem >= {1'b0, b}) begin
                rem  = rem - {1'b0, b};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // sigmoid table entry, evaluated at elaboration only
    function automatic logic [YW-1:0] f_sig_entry(input int i, input int n);
        longint num;
        longint unsigned mag, s, e, term, r, d, p;
        num  = 16 * longint'(i) - 8 * longint'(n);
        mag  = (num < 0) ? longint'(-num) : longint'(num);
        s    = f_udiv(mag << 26, 64'(n));
        e    = 64'd1 << 30;
        term = 64'd1 << 30;
        for (int k = 1; k <= 14; k++) begin
            term = f_udiv((term * s) >> 30, 64'(k));
            e    = e + term;
        end
        r = f_udiv(64'd1 << 60, e);
        for (int k = 0; k < 4; k++) begin
            r = (r * r) >> 30;
        end
        d = (64'd1 << 30) + r;
        p = f_udiv((64'd1 << 46) + (d >> 1), d);
        if (num < 0) begin
            p = 64'd65536 - p;
        end
        if (p > 64'd65535) begin
            p = 64'd65535;
        end
        return p[YW-1:0];
    endfunction

endpackage

FILE: design/mbp_req_if.sv
interface mbp_req_if;
    import mbp_pkg::*;
    logic            valid;
    logic            ready;
    logic            opcode;
    t_q              input_a;
    t_q              input_b;
    t_q              target;
    logic [IXW-1:0]  weight_index;
    t_q              weight_value;

    modport source (output valid, opcode, input_a, input_b, target, weight_index,
                    weight_value, input ready);
    modport sink   (input valid, opcode, input_a, input_b, target, weight_index,
                    weight_value, output ready);
endinterface

FILE: design/mbp_rsp_if.sv
interface mbp_rsp_if;
    import mbp_pkg::*;
    logic           valid;
    logic           ready;
    logic [YW-1:0]  prediction;
    t_q             output_error;

    modport source (output valid, prediction, output_error, input ready);
    modport sink   (input valid, prediction, output_error, output ready);
endinterface

FILE: design/mbp_sig.sv
module mbp_sig
    import mbp_pkg::*;
#(
    parameter int ENTRIES = SIG_ENTRIES_DEF
) (
    input  t_q             i_act,
    output logic [YW-1:0]  o_y
);
    localparam int IW  = $clog2(ENTRIES);
    localparam int MW  = 21 + IW;
    localparam int LIM = 524288;

    typedef logic [YW-1:0] t_rom [ENTRIES];

    function automatic t_rom f_build();
        t_rom rr;
        for (int i = 0; i < ENTRIES; i++) begin
            rr[i] = f_sig_entry(i, ENTRIES);
        end
        return rr;
    endfunction

    localparam t_rom ROM = f_build();

    logic [19:0]    w_u;
    logic [MW-1:0]  w_prod;
    logic [IW-1:0]  w_idx;

    always_comb begin
        w_u    = 20'(i_act + t_q'(LIM));
        w_prod = MW'(w_u) * MW'(ENTRIES);
        if (i_act < -LIM) begin
            w_idx = '0;
        end else if (i_act >= LIM) begin
            w_idx = IW'(ENTRIES - 1);
        end else begin
            w_idx = w_prod[20 +: IW];
        end
        o_y = ROM[w_idx];
    end

endmodule

FILE: design/mbp_lane.sv
module mbp_lane
    import mbp_pkg::*;
#(
    parameter int ENTRIES = SIG_ENTRIES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_ctl            i_ctl,
    input  t_lane_ld        i_ld,
    input  t_q              i_ld_val,
    input  t_q              i_xa,
    input  t_q              i_xb,
    input  t_q              i_do,
    input  t_p              i_pob,
    input  logic [LRW-1:0]  i_lr,
    output t_p              o_po
);
    t_q                      r_wa, r_wb, r_b, r_ow;
    logic signed [47:0]      r_pa, r_pb, r_pe;
    t_q                      r_act, r_e, r_dh;
    logic [YW-1:0]           r_h;
    logic [YW-1:0]           w_h;
    logic [YW:0]             r_dsh;
    logic signed [57:0]      r_pw;
    logic signed [41:0]      r_pdh;
    t_p                      r_pl;
    t_p                      r_po;
    logic signed [64:0]      r_pxa, r_pxb;

    mbp_sig #(.ENTRIES(ENTRIES)) u_sig (
        .i_act (r_act),
        .o_y   (w_h)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wa <= '0;
            r_wb <= '0;
            r_b  <= '0;
            r_ow <= '0;
        end else begin
            if (i_ld.wa) r_wa <= i_ld_val;
            if (i_ld.wb) r_wb <= i_ld_val;
            if (i_ld.b)  r_b  <= i_ld_val;
            if (i_ld.ow) r_ow <= i_ld_val;
            if (i_ctl.b3) begin
                r_ow <= f_sat(WIDE'(r_ow) + f_rnd(WIDE'(r_pw), 32));
            end
            if (i_ctl.b6) begin
                r_b <= f_sat(WIDE'(r_b) + f_rnd(WIDE'(r_pl), 16));
            end
            if (i_ctl.b7) begin
                r_wa <= f_sat(WIDE'(r_wa) + f_rnd(WIDE'(r_pxa), 32));
                r_wb <= f_sat(WIDE'(r_wb) + f_rnd(WIDE'(r_pxb), 32));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.f1) begin
            r_pa <= 48'(i_xa) * 48'(r_wa);
            r_pb <= 48'(i_xb) * 48'(r_wb);
        end
        if (i_ctl.f2) begin
            r_act <= f_sat(f_rnd(WIDE'($signed({r_b, 16'b0})) + WIDE'(r_pa) + WIDE'(r_pb),
                                 16));
        end
        if (i_ctl.f3) r_h <= w_h;
        if (i_ctl.f4) r_po <= PW'($signed({1'b0, r_h})) * PW'(r_ow);
        if (i_ctl.b1) r_pe <= 48'(i_do) * 48'(r_ow);
        if (i_ctl.b2) begin
            r_e   <= f_sat(f_rnd(WIDE'(r_pe), 16));
            r_dsh <= f_dsig(r_h);
            r_pw  <= 58'($signed({1'b0, r_h})) * 58'(i_pob);
        end
        if (i_ctl.b3) r_pdh <= 42'(r_e) * 42'($signed({1'b0, r_dsh}));
        if (i_ctl.b4) r_dh <= f_sat(f_rnd(WIDE'(r_pdh), 16));
        if (i_ctl.b5) r_pl <= PW'(r_dh) * PW'($signed({1'b0, i_lr}));
        if (i_ctl.b6) begin
            r_pxa <= 65'(i_xa) * 65'(r_pl);
            r_pxb <= 65'(i_xb) * 65'(r_pl);
        end
    end

    assign o_po = r_po;

endmodule

FILE: design/mbp_merge.sv
module mbp_merge
    import mbp_pkg::*;
#(
    parameter int HIDDEN  = HIDDEN_DEF,
    parameter int ENTRIES = SIG_ENTRIES_DEF,
    parameter int CW      = (HIDDEN > 1) ? $clog2(HIDDEN) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_ctl            i_ctl,
    input  logic [CW-1:0]   i_sel,
    input  t_p              i_po [HIDDEN],
    input  logic            i_ld,
    input  t_q              i_ld_val,
    input  t_q              i_tgt,
    input  logic [LRW-1:0]  i_lr,
    output logic [YW-1:0]   o_y,
    output t_q              o_err,
    output t_q              o_do,
    output t_p              o_pob
);
    localparam int ACCW = PW + $clog2(HIDDEN + 1) + 1;

    t_q                      r_ob;
    logic signed [ACCW-1:0]  r_acc;
    t_q                      r_act, r_err, r_do;
    logic [YW-1:0]           r_y, w_y;
    logic [YW:0]             r_dy;
    logic signed [41:0]      r_pd;
    t_p                      r_pob;

    mbp_sig #(.ENTRIES(ENTRIES)) u_sig (
        .i_act (r_act),
        .o_y   (w_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob <= '0;
        end else begin
            if (i_ld) r_ob <= i_ld_val;
            if (i_ctl.b2) r_ob <= f_sat(WIDE'(r_ob) + f_rnd(WIDE'(r_pob), 16));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.f4)  r_acc <= ACCW'($signed({r_ob, 16'b0}));
        if (i_ctl.sum) r_acc <= r_acc + ACCW'(i_po[i_sel]);
        if (i_ctl.o1)  r_act <= f_sat(f_rnd(WIDE'(r_acc), 16));
        if (i_ctl.o2)  r_y <= w_y;
        if (i_ctl.e1) begin
            r_err <= f_sat(WIDE'(i_tgt) - WIDE'($signed({1'b0, r_y})));
            r_dy  <= f_dsig(r_y);
        end
        if (i_ctl.e2) r_pd <= 42'(r_err) * 42'($signed({1'b0, r_dy}));
        if (i_ctl.e3) r_do <= f_sat(f_rnd(WIDE'(r_pd), 16));
        if (i_ctl.b1) r_pob <= PW'(r_do) * PW'($signed({1'b0, i_lr}));
    end

    assign o_y   = r_y;
    assign o_err = r_err;
    assign o_do  = r_do;
    assign o_pob = r_pob;

endmodule

FILE: design/mlp_backprop_train_step.sv
// online sgd trainer for a two-input network with HIDDEN sigmoid hidden neurons and one
// sigmoid output, all values signed q8.16 with saturation. a train request (opcode 0)
// returns the forward prediction (q0.16) and target minus prediction, then updates every
// weight and bias by learning_rate times its gradient before the next request is taken.
// a load request (opcode 1) writes one weight or bias at weight_index (hidden weights,
// hidden biases, output weights, output bias; anything past the output bias is ignored)
// and returns zeros. one lane per hidden neuron holds that neuron's weights and does its
// share of forward and backward work; a merge unit accumulates the lane products one per
// cycle into the output neuron. a train request runs through the chain of registered
// multiplies and the serial accumulation over the lanes; either kind of request waits
// for a free output register. one request is in flight at a time; a response waits in
// an output register. learning_rate may only be written while the block is idle.
module mlp_backprop_train_step
    import mbp_pkg::*;
#(
    parameter int HIDDEN      = HIDDEN_DEF,
    parameter int SIG_ENTRIES = SIG_ENTRIES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mbp_req_if.sink          i_req,
    mbp_rsp_if.source        o_rsp,
    input  logic             i_cfg_we,
    input  logic [LRW-1:0]   i_cfg_wdata
);
    localparam int CW = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;

    typedef enum logic [4:0] {
        S_IDLE, S_F1, S_F2, S_F3, S_F4, S_SUM, S_O1, S_O2,
        S_E1, S_E2, S_E3, S_B1, S_B2, S_B3, S_B4, S_B5, S_B6, S_B7, S_LD
    } t_state;

    t_state           r_state;
    logic [CW-1:0]    r_cnt;
    logic [LRW-1:0]   r_lr;
    t_q               r_xa, r_xb, r_tgt;
    logic             r_o_valid;
    logic [YW-1:0]    r_o_pred;
    t_q               r_o_err;

    t_ctl             w_ctl;
    logic             w_accept;
    logic             w_load;
    logic             w_slot_free;
    logic             w_rsp_load;
    t_lane_ld         w_ld [HIDDEN];
    logic             w_ld_ob;
    t_p               w_po [HIDDEN];
    logic [YW-1:0]    w_y;
    t_q               w_err, w_do;
    t_p               w_pob;

    // request handshake: only taken between items
    assign i_req.ready  = (r_state == S_IDLE);
    assign w_accept     = i_req.valid && i_req.ready;
    assign w_load       = w_accept && (t_op'(i_req.opcode) == OP_LOAD);
    assign w_slot_free  = !r_o_valid || o_rsp.ready;
    // response register is filled this cycle
    assign w_rsp_load   = w_slot_free && (r_state == S_E2 || r_state == S_LD);

    // flat index decode for loads
    genvar g;
    generate
        for (g = 0; g < HIDDEN; g++) begin : g_lane
            always_comb begin
                w_ld[g].wa = w_load && (i_req.weight_index == IXW'(g));
                w_ld[g].wb = w_load && (i_req.weight_index == IXW'(HIDDEN + g));
                w_ld[g].b  = w_load && (i_req.weight_index == IXW'(2 * HIDDEN + g));
                w_ld[g].ow = w_load && (i_req.weight_index == IXW'(3 * HIDDEN + g));
            end

            mbp_lane #(.ENTRIES(SIG_ENTRIES)) u_lane (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (w_ctl),
                .i_ld     (w_ld[g]),
                .i_ld_val (i_req.weight_value),
                .i_xa     (r_xa),
                .i_xb     (r_xb),
                .i_do     (w_do),
                .i_pob    (w_pob),
                .i_lr     (r_lr),
                .o_po     (w_po[g])
            );
        end
    endgenerate

    assign w_ld_ob = w_load && (i_req.weight_index == IXW'(4 * HIDDEN));

    mbp_merge #(.HIDDEN(HIDDEN), .ENTRIES(SIG_ENTRIES), .CW(CW)) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_sel    (r_cnt),
        .i_po     (w_po),
        .i_ld     (w_ld_ob),
        .i_ld_val (i_req.weight_value),
        .i_tgt    (r_tgt),
        .i_lr     (r_lr),
        .o_y      (w_y),
        .o_err    (w_err),
        .o_do     (w_do),
        .o_pob    (w_pob)
    );

    // step strobes; e2 waits on the output register, so its work repeats harmlessly
    always_comb begin
        w_ctl = '0;
        unique case (r_state)
            S_F1:  w_ctl.f1  = 1'b1;
            S_F2:  w_ctl.f2  = 1'b1;
            S_F3:  w_ctl.f3  = 1'b1;
            S_F4:  w_ctl.f4  = 1'b1;
            S_SUM: w_ctl.sum = 1'b1;
            S_O1:  w_ctl.o1  = 1'b1;
            S_O2:  w_ctl.o2  = 1'b1;
            S_E1:  w_ctl.e1  = 1'b1;
            S_E2:  w_ctl.e2  = 1'b1;
            S_E3:  w_ctl.e3  = 1'b1;
            S_B1:  w_ctl.b1  = 1'b1;
            S_B2:  w_ctl.b2  = 1'b1;
            S_B3:  w_ctl.b3  = 1'b1;
            S_B4:  w_ctl.b4  = 1'b1;
            S_B5:  w_ctl.b5  = 1'b1;
            S_B6:  w_ctl.b6  = 1'b1;
            S_B7:  w_ctl.b7  = 1'b1;
            S_IDLE, S_LD: w_ctl = '0;
            default: w_ctl = '0;
        endcase
    end

    // sequencer, config register and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_lr      <= LR_RESET;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_lr <= i_cfg_wdata;
            if (o_rsp.valid && o_rsp.ready && !w_rsp_load) r_o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_xa  <= i_req.input_a;
                        r_xb  <= i_req.input_b;
                        r_tgt <= i_req.target;
                        r_state <= (t_op'(i_req.opcode) == OP_LOAD) ? S_LD : S_F1;
                    end
                end
                S_F1: r_state <= S_F2;
                S_F2: r_state <= S_F3;
                S_F3: r_state <= S_F4;
                S_F4: begin
                    r_cnt   <= '0;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    if (r_cnt == CW'(HIDDEN - 1)) begin
                        r_state <= S_O1;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_O1: r_state <= S_O2;
                S_O2: r_state <= S_E1;
                S_E1: r_state <= S_E2;
                S_E2: begin
                    // prediction and error are final here
                    if (w_slot_free) begin
                        r_o_valid <= 1'b1;
                        r_o_pred  <= w_y;
                        r_o_err   <= w_err;
                        r_state   <= S_E3;
                    end
                end
                S_E3: r_state <= S_B1;
                S_B1: r_state <= S_B2;
                S_B2: r_state <= S_B3;
                S_B3: r_state <= S_B4;
                S_B4: r_state <= S_B5;
                S_B5: r_state <= S_B6;
                S_B6: r_state <= S_B7;
                S_B7: r_state <= S_IDLE;
                S_LD: begin
                    if (w_slot_free) begin
                        r_o_valid <= 1'b1;
                        r_o_pred  <= '0;
                        r_o_err   <= '0;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid        = r_o_valid;
    assign o_rsp.prediction   = r_o_pred;
    assign o_rsp.output_error = r_o_err;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_req.ready)
        else $error("request taken while an item is in flight");

    a_rsp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> ($past(r_state) == S_E2 || $past(r_state) == S_LD))
        else $error("response raised outside a result step");

    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_ctl))
        else $error("more than one step strobe active");

    a_sum_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) |-> (r_cnt <= CW'(HIDDEN - 1)))
        else $error("lane select out of range");
`endif

endmodule
